@@ design/bdc_pkg.sv @@
// Shared constants and types for the Bezier de Casteljau evaluator.
// No dependencies; imported by bdc_lerp, bdc_ctrl and the top level.
package bdc_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_POINTS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int CFG_BITS   = 5;
  localparam int T_BITS     = 17;
  localparam int FIELD_IDX_BITS = 4;
  localparam int FIELD_CRD_BITS = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } coord_pair_t;

  localparam int PAIR_BITS = $bits(coord_pair_t);

  typedef struct packed {
    logic                vld;
    coord_pair_t         p;
    coord_pair_t         q;
    logic [T_BITS-1:0]   t;
    logic [IDX_BITS-1:0] idx;
  } lerp_req_t;

  typedef struct packed {
    logic                busy;
    logic                vld;
    logic [IDX_BITS-1:0] idx;
    coord_pair_t         res;
  } lerp_rsp_t;

endpackage

@@ design/bdc_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module bdc_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/bdc_lerp.sv @@
// Two-stage pipelined linear interpolator for an x,y pair, t in unsigned Q1.16.
// Depends on bdc_pkg.
module bdc_lerp (
  input  logic              clk,
  input  logic              rst_n,
  input  bdc_pkg::lerp_req_t req,
  output bdc_pkg::lerp_rsp_t rsp
);
  import bdc_pkg::*;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + T_BITS + 1;
  localparam int SHR_W  = PROD_W - 16;

  logic                       v1_r, v2_r;
  logic [IDX_BITS-1:0]        idx1_r, idx2_r;
  coord_pair_t                p1_r, p2_r;
  logic [T_BITS-1:0]          t1_r;
  logic signed [DIFF_W-1:0]   dx_r, dy_r;
  logic signed [PROD_W-1:0]   px_r, py_r;
  logic signed [DIFF_W-1:0]   dx_nxt, dy_nxt;
  logic signed [PROD_W-1:0]   px_nxt, py_nxt;
  logic signed [SHR_W-1:0]    sx, sy;

  assign dx_nxt = DIFF_W'(req.q.x) - DIFF_W'(req.p.x);
  assign dy_nxt = DIFF_W'(req.q.y) - DIFF_W'(req.p.y);
  assign px_nxt = PROD_W'(dx_r) * PROD_W'($signed({1'b0, t1_r}));
  assign py_nxt = PROD_W'(dy_r) * PROD_W'($signed({1'b0, t1_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r   <= req.p;
    t1_r   <= req.t;
    idx1_r <= req.idx;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    p2_r   <= p1_r;
    idx2_r <= idx1_r;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
  end

  // arithmetic shift floors toward minus infinity
  assign sx = px_r[PROD_W-1:16] + SHR_W'(p2_r.x);
  assign sy = py_r[PROD_W-1:16] + SHR_W'(p2_r.y);

  assign rsp.busy  = v1_r;
  assign rsp.vld   = v2_r;
  assign rsp.idx   = idx2_r;
  assign rsp.res.x = sx[COORD_BITS-1:0];
  assign rsp.res.y = sy[COORD_BITS-1:0];

endmodule

@@ design/bdc_ctrl.sv @@
// Evaluation sequencer: level/index scan over the point and work memories,
// drain interlock between levels, result register. Depends on bdc_pkg.
module bdc_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [bdc_pkg::FIELD_IDX_BITS-1:0] in_index,
  input  bdc_pkg::coord_pair_t           in_pt,
  input  logic [bdc_pkg::T_BITS-1:0]     in_t,
  input  logic                           cfg_we,
  input  logic [bdc_pkg::CFG_BITS-1:0]   cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdc_pkg::coord_pair_t           out_pt,
  output logic                           pt_we,
  output logic [bdc_pkg::IDX_BITS-1:0]   pt_waddr,
  output bdc_pkg::coord_pair_t           pt_wdata,
  output logic [bdc_pkg::IDX_BITS-1:0]   rd_addr,
  input  bdc_pkg::coord_pair_t           pt_rdata,
  input  bdc_pkg::coord_pair_t           wk_rdata,
  output bdc_pkg::lerp_req_t             req,
  input  bdc_pkg::lerp_rsp_t             rsp
);
  import bdc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_CATCH = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [CFG_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] n_r, n_nxt, n_sat;
  logic [T_BITS-1:0]   t_r, t_nxt;
  logic [IDX_BITS-1:0] level_r, level_nxt;
  logic [IDX_BITS-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_BITS-1:0] rd_idx_d_r, rd_idx_d_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_first_r, rd_first_nxt;
  logic                rd_pt_r, rd_pt_nxt;
  logic                out_vld_r, out_vld_nxt;
  coord_pair_t         out_pt_r, out_pt_nxt;
  coord_pair_t         res_r, res_nxt;
  coord_pair_t         prev_r;
  coord_pair_t         rd_data;
  logic                in_fire;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_data  = rd_pt_r ? pt_rdata : wk_rdata;

  assign pt_we    = in_fire && (in_op == OP_LOAD) && (int'(in_index) < MAX_POINTS);
  assign pt_waddr = IDX_BITS'(in_index);
  assign pt_wdata = in_pt;

  always_comb begin
    if (cnt_r == '0) begin
      n_sat = CNT_BITS'(1);
    end else if (int'(cnt_r) > MAX_POINTS) begin
      n_sat = CNT_BITS'(MAX_POINTS);
    end else begin
      n_sat = CNT_BITS'(cnt_r);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    t_nxt        = t_r;
    level_nxt    = level_r;
    rd_idx_nxt   = rd_idx_r;
    rd_idx_d_nxt = rd_idx_d_r;
    rd_vld_nxt   = 1'b0;
    rd_first_nxt = rd_first_r;
    rd_pt_nxt    = rd_pt_r;
    out_vld_nxt  = out_vld_r;
    out_pt_nxt   = out_pt_r;
    res_nxt      = res_r;
    rd_addr      = '0;
    if (cfg_we) begin
      cnt_nxt = cfg_wdata;
    end
    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_op == OP_EVAL)) begin
          t_nxt      = (in_t > T_ONE) ? T_ONE : in_t;
          n_nxt      = n_sat;
          level_nxt  = IDX_BITS'(1);
          rd_idx_nxt = '0;
          state_nxt  = (n_sat == CNT_BITS'(1)) ? ST_FETCH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr      = rd_idx_r;
        rd_vld_nxt   = 1'b1;
        rd_first_nxt = (rd_idx_r == '0);
        rd_pt_nxt    = (level_r == IDX_BITS'(1));
        rd_idx_d_nxt = rd_idx_r;
        if (CNT_BITS'(rd_idx_r) == n_r - CNT_BITS'(level_r)) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_BITS'(1);
        end
      end
      ST_DRAIN: begin
        // wait until every write of this level has landed
        if (!rd_vld_r && !rsp.busy && !rsp.vld) begin
          if (CNT_BITS'(level_r) + CNT_BITS'(1) == n_r) begin
            state_nxt = ST_FETCH;
          end else begin
            level_nxt  = level_r + IDX_BITS'(1);
            rd_idx_nxt = '0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_FETCH: begin
        rd_addr   = '0;
        rd_pt_nxt = (n_r == CNT_BITS'(1));
        state_nxt = ST_CATCH;
      end
      ST_CATCH: begin
        res_nxt   = rd_data;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_r || out_ready) begin
          out_pt_nxt  = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= CFG_BITS'(1);
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    t_r        <= t_nxt;
    level_r    <= level_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_idx_d_r <= rd_idx_d_nxt;
    rd_first_r <= rd_first_nxt;
    rd_pt_r    <= rd_pt_nxt;
    out_pt_r   <= out_pt_nxt;
    res_r      <= res_nxt;
    if (rd_vld_r) begin
      prev_r <= rd_data;
    end
  end

  assign req.vld = rd_vld_r && !rd_first_r;
  assign req.p   = prev_r;
  assign req.q   = rd_data;
  assign req.t   = t_r;
  assign req.idx = rd_idx_d_r - IDX_BITS'(1);

  assign out_valid = out_vld_r;
  assign out_pt    = out_pt_r;

`ifndef SYNTHESIS
  a_wr_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("work write outside a scan");
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.vld |-> (CNT_BITS'(rsp.idx) + CNT_BITS'(1) < n_r))
    else $error("work write beyond active points");
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (CNT_BITS'(level_r) < n_r))
    else $error("level out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(out_pt_r)))
    else $error("result dropped while stalled");
  a_catch_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CATCH) |=> (state_r == ST_OUT))
    else $error("capture not followed by output");
`endif

endmodule

@@ design/bezier_de_casteljau_eval.sv @@
// Top level of the Bezier de Casteljau evaluator: stream ports, point and
// work memories, interpolator and sequencer. Depends on bdc_pkg and submodules.
//
// A load transaction (tuser = 0) writes one control point.
// An evaluate transaction (tuser = 1) runs de Casteljau over the first
// point_count points (0 reads as 1, above 16 as 16) with t saturated to 1.0:
// every level streams its points through the read address shared by the point
// and work memories, and waits for the interpolator pipeline to write back
// before the next level starts. One evaluation is in flight at a time; a new
// transaction is taken while a finished result waits on the output. Point
// store contents are undefined until loaded.
module bezier_de_casteljau_eval (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_index[3:0], point_x[19:4], point_y[35:20], param_t[52:36], zero pad
  input  logic [bdc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode[0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // curve_x[15:0], curve_y[31:16]
  output logic [bdc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [bdc_pkg::CFG_BITS-1:0]      cfg_wdata
);
  import bdc_pkg::*;

  logic [FIELD_IDX_BITS-1:0]        in_index;
  logic signed [FIELD_CRD_BITS-1:0] in_x, in_y;
  logic [T_BITS-1:0]                in_t;
  coord_pair_t                      in_pt, out_pt;
  logic                             pt_we;
  logic [IDX_BITS-1:0]              pt_waddr, rd_addr;
  coord_pair_t                      pt_wdata, pt_rdata, wk_rdata;
  lerp_req_t                        req;
  lerp_rsp_t                        rsp;

  assign in_index = in_tdata[3:0];
  assign in_x     = in_tdata[19:4];
  assign in_y     = in_tdata[35:20];
  assign in_t     = in_tdata[52:36];
  assign in_pt.x  = COORD_BITS'(in_x);
  assign in_pt.y  = COORD_BITS'(in_y);

  bdc_ram #(.DEPTH(MAX_POINTS), .WIDTH(PAIR_BITS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (rd_addr),
    .rdata (pt_rdata)
  );

  bdc_ram #(.DEPTH(MAX_POINTS), .WIDTH(PAIR_BITS)) u_wk_ram (
    .clk   (clk),
    .we    (rsp.vld),
    .waddr (rsp.idx),
    .wdata (rsp.res),
    .raddr (rd_addr),
    .rdata (wk_rdata)
  );

  bdc_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  bdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[0]),
    .in_index  (in_index),
    .in_pt     (in_pt),
    .in_t      (in_t),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pt    (out_pt),
    .pt_we     (pt_we),
    .pt_waddr  (pt_waddr),
    .pt_wdata  (pt_wdata),
    .rd_addr   (rd_addr),
    .pt_rdata  (pt_rdata),
    .wk_rdata  (wk_rdata),
    .req       (req),
    .rsp       (rsp)
  );

  assign out_tdata = {FIELD_CRD_BITS'(out_pt.y), FIELD_CRD_BITS'(out_pt.x)};

endmodule
